/* src/isp_pkg.sv */
package isp_pkg;

    localparam int MAX_SEGS           = 32;
    localparam int MIN_SEGMENT_PIXELS = 256;
    localparam int DIM_BITS           = 16;

    localparam logic [15:0] DIM_MASK = 16'((64'd1 << DIM_BITS) - 64'd1);

    // Shared divider: the widest dividend is height * (cols * top rows) plus rounding,
    // and every divisor is a row, column or segment count of at most MAX_SEGS + 1.
    localparam int DVD_BITS = 22;
    localparam int DVS_BITS = 6;
    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    typedef logic [DVD_BITS-1:0] t_dvd;
    typedef logic [DVS_BITS-1:0] t_dvs;
    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef struct packed {
        logic [15:0] width_px;
        logic [15:0] height_px;
        logic [5:0]  segment_count;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  segment_index;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_start;
        logic [15:0] y_end;
        logic        last;
        logic        error;
    } t_out_item;

    typedef struct packed {
        logic start;
        t_dvd dividend;
        t_dvs divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_dvd quot;
        t_dvs rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AREA,
        S_HN,
        S_SEARCH,
        S_DIV_ROWS,
        S_CR,
        S_TOPH,
        S_DIV_TOP,
        S_DIV_XT,
        S_DIV_YT,
        S_EMIT,
        S_DIV_XB,
        S_DIV_YB,
        S_ERR
    } t_state;

endpackage

/* src/isp_div.sv */
module isp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isp_pkg::t_div_req i_req,
    output isp_pkg::t_div_rsp o_rsp
);

    logic          r_busy;
    logic          r_done;
    isp_pkg::t_cnt r_cnt;
    isp_pkg::t_dvd r_quot;
    isp_pkg::t_dvs r_rem;
    isp_pkg::t_dvs r_dvs;

    logic [isp_pkg::DVS_BITS:0]   partial;
    logic [isp_pkg::DVS_BITS+1:0] diff;
    logic                         fits;
    isp_pkg::t_dvs                n_rem;

    // One restoring step per cycle, most significant dividend bit first.
    always_comb begin
        partial = {r_rem, r_quot[isp_pkg::DVD_BITS-1]};
        diff    = {1'b0, partial} - {2'b00, r_dvs};
        fits    = !diff[isp_pkg::DVS_BITS+1];
        n_rem   = fits ? diff[isp_pkg::DVS_BITS-1:0] : partial[isp_pkg::DVS_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && !r_done && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= isp_pkg::t_cnt'(isp_pkg::DVD_BITS);
                r_rem  <= '0;
                r_quot <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[isp_pkg::DVD_BITS-2:0], fits};
                r_cnt  <= r_cnt - isp_pkg::t_cnt'(1);
                if (r_cnt == isp_pkg::t_cnt'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

/* src/image_segment_partitioner.sv */
// Each division runs in the shared 22-step divider, and the row search adds one segment row
// per step. Results leave at one per cycle when not stalled, up to 32 per item; an item with
// a bottom band pauses its results for two more divisions before that band. An error item
// gives its single result through S_AREA and S_ERR. The next item is accepted once the last
// result is registered. Reset is synchronous, active low, and returns the sequencer to idle.
module image_segment_partitioner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  isp_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output isp_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    isp_pkg::t_state r_state, n_state;

    logic [15:0] r_w, r_h;
    logic [5:0]  r_n;
    logic [21:0] r_hn;
    logic [5:0]  r_rows;
    logic [21:0] r_t;
    logic [27:0] r_p;
    logic [5:0]  r_cols, r_rows_top, r_rbot, r_cr;
    logic [21:0] r_dvd;
    logic [15:0] r_top_h;
    logic [15:0] r_xs, r_ys;
    logic [5:0]  r_nxs, r_nys;
    logic [5:0]  r_cols_cur, r_row, r_col;
    logic [4:0]  r_k;
    logic [15:0] r_x, r_y;

    isp_pkg::t_out_item r_out, n_out;
    logic               r_out_valid;

    logic [15:0] mul_a, mul_b;
    logic [31:0] mul_prod;
    logic        area_err;
    logic        search_go;
    logic [21:0] t_inc;
    logic [15:0] x_end, y_end, top_q;
    logic        slot_free, load_out;
    logic        row_end, last_row, top_end;

    isp_pkg::t_div_req div_req;
    isp_pkg::t_div_rsp div_rsp;

    isp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // The one multiplier is shared by the area check, height * count, cols * top rows and the top band size.
    always_comb begin
        unique case (r_state)
            isp_pkg::S_HN: begin
                mul_a = r_h;
                mul_b = 16'(r_n);
            end
            isp_pkg::S_CR: begin
                mul_a = 16'(r_cols);
                mul_b = 16'(r_rows_top);
            end
            isp_pkg::S_TOPH: begin
                mul_a = r_h;
                mul_b = 16'(r_cr);
            end
            default: begin
                mul_a = r_w;
                mul_b = r_h;
            end
        endcase
    end

    assign mul_prod = 32'(mul_a) * 32'(mul_b);

    always_comb begin
        div_req.start    = 1'b1;
        div_req.dividend = 22'(r_n);
        div_req.divisor  = r_rows;
        unique case (r_state)
            isp_pkg::S_DIV_ROWS: begin
                div_req.dividend = 22'(r_n);
                div_req.divisor  = r_rows;
            end
            isp_pkg::S_DIV_TOP: begin
                div_req.dividend = r_dvd;
                div_req.divisor  = r_n;
            end
            isp_pkg::S_DIV_XT: begin
                div_req.dividend = 22'(r_w);
                div_req.divisor  = r_cols;
            end
            isp_pkg::S_DIV_YT: begin
                div_req.dividend = 22'(r_top_h);
                div_req.divisor  = r_rows_top;
            end
            isp_pkg::S_DIV_XB: begin
                div_req.dividend = 22'(r_w);
                div_req.divisor  = r_cols_cur;
            end
            isp_pkg::S_DIV_YB: begin
                div_req.dividend = 22'(r_h - r_top_h);
                div_req.divisor  = r_rbot;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    assign area_err = (r_n == 6'd0) || ({1'b0, r_n} > 7'(isp_pkg::MAX_SEGS)) ||
                      (mul_prod < 32'(32'(r_n) * 32'(isp_pkg::MIN_SEGMENT_PIXELS)));

    // r_p holds rows*(rows+1)*w and r_t holds (rows+1)*w, so each step is two additions.
    assign search_go = (r_rows < r_n) && (r_p < 28'(r_hn));
    assign t_inc     = r_t + 22'(r_w);

    assign top_q = div_rsp.quot[15:0];
    assign x_end = r_x + r_xs + 16'(r_col >= r_nxs);
    assign y_end = r_y + r_ys + 16'(r_row >= r_nys);

    assign slot_free = !r_out_valid || !i_out_stall;
    assign row_end   = (r_col + 6'd1) == r_cols_cur;
    assign last_row  = (r_row + 6'd1) == r_rows;
    assign top_end   = (r_row + 6'd1) == r_rows_top;

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        n_out.segment_index = r_k;
        n_out.x_start       = r_x;
        n_out.x_end         = x_end;
        n_out.y_start       = r_y;
        n_out.y_end         = y_end;
        n_out.last          = ({1'b0, r_k} + 6'd1) == r_n;
        n_out.error         = 1'b0;
        unique case (r_state)
            isp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = isp_pkg::S_AREA;
                end
            end
            isp_pkg::S_AREA: begin
                n_state = area_err ? isp_pkg::S_ERR : isp_pkg::S_HN;
            end
            isp_pkg::S_HN: begin
                n_state = isp_pkg::S_SEARCH;
            end
            isp_pkg::S_SEARCH: begin
                if (!search_go) begin
                    n_state = isp_pkg::S_DIV_ROWS;
                end
            end
            isp_pkg::S_DIV_ROWS: begin
                if (div_rsp.done) begin
                    n_state = isp_pkg::S_CR;
                end
            end
            isp_pkg::S_CR: begin
                n_state = isp_pkg::S_TOPH;
            end
            isp_pkg::S_TOPH: begin
                n_state = isp_pkg::S_DIV_TOP;
            end
            isp_pkg::S_DIV_TOP: begin
                if (div_rsp.done) begin
                    n_state = isp_pkg::S_DIV_XT;
                end
            end
            isp_pkg::S_DIV_XT: begin
                if (div_rsp.done) begin
                    n_state = isp_pkg::S_DIV_YT;
                end
            end
            isp_pkg::S_DIV_YT: begin
                if (div_rsp.done) begin
                    n_state = isp_pkg::S_EMIT;
                end
            end
            isp_pkg::S_EMIT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    if (row_end && last_row) begin
                        n_state = isp_pkg::S_IDLE;
                    end else if (row_end && top_end) begin
                        n_state = isp_pkg::S_DIV_XB;
                    end
                end
            end
            isp_pkg::S_DIV_XB: begin
                if (div_rsp.done) begin
                    n_state = isp_pkg::S_DIV_YB;
                end
            end
            isp_pkg::S_DIV_YB: begin
                if (div_rsp.done) begin
                    n_state = isp_pkg::S_EMIT;
                end
            end
            isp_pkg::S_ERR: begin
                n_out = '0;
                n_out.last  = 1'b1;
                n_out.error = 1'b1;
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = isp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = isp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            isp_pkg::S_IDLE: begin
                r_w <= i_in_data.width_px & isp_pkg::DIM_MASK;
                r_h <= i_in_data.height_px & isp_pkg::DIM_MASK;
                r_n <= i_in_data.segment_count;
            end
            isp_pkg::S_HN: begin
                r_hn   <= mul_prod[21:0];
                r_rows <= 6'd1;
                r_t    <= 22'({r_w, 1'b0});
                r_p    <= 28'({r_w, 1'b0});
            end
            isp_pkg::S_SEARCH: begin
                if (search_go) begin
                    r_rows <= r_rows + 6'd1;
                    r_t    <= t_inc;
                    r_p    <= r_p + 28'({r_t, 1'b0});
                end
            end
            isp_pkg::S_DIV_ROWS: begin
                if (div_rsp.done) begin
                    r_cols     <= div_rsp.quot[5:0];
                    r_rows_top <= r_rows - div_rsp.rem;
                    r_rbot     <= div_rsp.rem;
                end
            end
            isp_pkg::S_CR: begin
                r_cr <= mul_prod[5:0];
            end
            isp_pkg::S_TOPH: begin
                r_dvd <= mul_prod[21:0] + 22'(r_n >> 1);
            end
            isp_pkg::S_DIV_TOP: begin
                if (div_rsp.done) begin
                    r_top_h <= (top_q < 16'(r_rows_top)) ? 16'(r_rows_top) : top_q;
                end
            end
            isp_pkg::S_DIV_XT: begin
                if (div_rsp.done) begin
                    r_xs       <= div_rsp.quot[15:0];
                    r_nxs      <= r_cols - div_rsp.rem;
                    r_cols_cur <= r_cols;
                end
            end
            isp_pkg::S_DIV_YT: begin
                if (div_rsp.done) begin
                    r_ys  <= div_rsp.quot[15:0];
                    r_nys <= r_rows_top - div_rsp.rem;
                    r_row <= '0;
                    r_col <= '0;
                    r_k   <= '0;
                    r_x   <= '0;
                    r_y   <= '0;
                end
            end
            isp_pkg::S_EMIT: begin
                if (load_out) begin
                    r_k <= r_k + 5'd1;
                    if (row_end) begin
                        r_col <= '0;
                        r_x   <= '0;
                        r_y   <= y_end;
                        r_row <= r_row + 6'd1;
                        if (top_end) begin
                            r_cols_cur <= r_cols_cur + 6'd1;
                        end
                    end else begin
                        r_col <= r_col + 6'd1;
                        r_x   <= x_end;
                    end
                end
            end
            isp_pkg::S_DIV_XB: begin
                if (div_rsp.done) begin
                    r_xs  <= div_rsp.quot[15:0];
                    r_nxs <= r_cols_cur - div_rsp.rem;
                end
            end
            isp_pkg::S_DIV_YB: begin
                if (div_rsp.done) begin
                    r_ys  <= div_rsp.quot[15:0];
                    r_nys <= r_rbot - div_rsp.rem + r_rows_top;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = r_state != isp_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error) |-> o_out_data.last)
        else $error("error result without last");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == isp_pkg::S_AREA))
        else $error("accepted item did not start the sequencer");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == isp_pkg::S_DIV_ROWS || r_state == isp_pkg::S_DIV_TOP ||
                          r_state == isp_pkg::S_DIV_XT || r_state == isp_pkg::S_DIV_YT ||
                          r_state == isp_pkg::S_DIV_XB || r_state == isp_pkg::S_DIV_YB))
        else $error("divider finished outside a division step");

    a_emit_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == isp_pkg::S_EMIT) |-> ((r_col < r_cols_cur) && (r_row < r_rows)))
        else $error("emission position out of range");

endmodule

/* tb/isp_segment_checker.sv */
module isp_segment_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  isp_pkg::t_in_item  i_in_data,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  isp_pkg::t_out_item i_out_data,
    input  logic               i_out_stall,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    isp_pkg::t_out_item expected_segments[$];
    int                 mismatch_count = 0;
    int                 pending_count  = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_count;

    // The first small_count pieces get size, the rest get size + 1.
    function automatic void even_split(input longint total, input longint parts,
                                       output longint size, output longint small_count);
        longint p;
        p = (parts < 1) ? 1 : parts;
        size        = total / p;
        small_count = (size + 1) * p - total;
    endfunction

    function automatic void partition_image(input isp_pkg::t_in_item req);
        longint             w, h, n;
        longint             rows, cols, rows_top, top_h;
        longint             xs, nxs, ys, nys;
        longint             x, y, xnext, ynext, i, j;
        int                 k;
        isp_pkg::t_out_item seg;
        isp_pkg::t_out_item segs[$];
        w = longint'(req.width_px & isp_pkg::DIM_MASK);
        h = longint'(req.height_px & isp_pkg::DIM_MASK);
        n = longint'(req.segment_count);
        seg = '0;
        if (n == 0 || n > isp_pkg::MAX_SEGS || w * h < n * isp_pkg::MIN_SEGMENT_PIXELS) begin
            seg.last  = 1'b1;
            seg.error = 1'b1;
            expected_segments.push_back(seg);
            return;
        end
        rows = 1;
        while (rows < n && (rows + 1) * rows * w < h * n) begin
            rows++;
        end
        even_split(n, rows, cols, rows_top);
        top_h = (h * cols * rows_top + n / 2) / n;
        if (top_h < rows_top) begin
            top_h = rows_top;
        end
        even_split(w, cols, xs, nxs);
        even_split(top_h, rows_top, ys, nys);
        k = 0;
        y = 0;
        for (i = 0; i < rows; i++) begin
            // The bottom band starts here: one more column per row and its own heights.
            if (i == rows_top) begin
                cols++;
                even_split(w, cols, xs, nxs);
                even_split(h - top_h, rows - rows_top, ys, nys);
                nys += rows_top;
            end
            ynext = y + ys + ((i >= nys) ? 1 : 0);
            x = 0;
            for (j = 0; j < cols && k < isp_pkg::MAX_SEGS; j++) begin
                xnext = x + xs + ((j >= nxs) ? 1 : 0);
                seg.segment_index = 5'(k);
                seg.x_start       = 16'(x);
                seg.x_end         = 16'(xnext);
                seg.y_start       = 16'(y);
                seg.y_end         = 16'(ynext);
                seg.last          = (longint'(k + 1) == n);
                seg.error         = 1'b0;
                segs.push_back(seg);
                x = xnext;
                k++;
            end
            y = ynext;
        end
        if (k > 0) begin
            segs[k - 1].last = 1'b1;
        end
        foreach (segs[m]) begin
            expected_segments.push_back(segs[m]);
        end
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        isp_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                partition_image(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_segments.size() == 0) begin
                    $display("%0t: unexpected segment, expected none, got %h",
                             $time, i_out_data);
                    mismatch_count++;
                end else begin
                    want = expected_segments.pop_front();
                    check_field("segment_index", want.segment_index, i_out_data.segment_index);
                    check_field("x_start", want.x_start, i_out_data.x_start);
                    check_field("x_end", want.x_end, i_out_data.x_end);
                    check_field("y_start", want.y_start, i_out_data.y_start);
                    check_field("y_end", want.y_end, i_out_data.y_end);
                    check_field("last", want.last, i_out_data.last);
                    check_field("error", want.error, i_out_data.error);
                end
            end
            pending_count <= expected_segments.size();
        end
    end

endmodule

/* tb/image_segment_partitioner_tb.sv */
module image_segment_partitioner_tb;

    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 300;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    isp_pkg::t_in_item  i_in_data   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    isp_pkg::t_out_item o_out_data;
    logic               i_out_stall = 1'b0;

    int mismatches;
    int outstanding;
    int send_idle_pct    = 0;
    int out_stall_pct    = 0;
    bit hold_off_pending = 1'b0;
    int quiet_cycles     = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    image_segment_partitioner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    isp_segment_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_in_stall    (o_in_stall),
        .i_out_valid   (o_out_valid),
        .i_out_data    (o_out_data),
        .i_out_stall   (i_out_stall),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic int random_dim();
        case ($urandom_range(3))
            0: return $urandom_range(1, 65535);
            1: return $urandom_range(1, 64);
            2: return $urandom_range(64, 2048);
            default: return $urandom_range(60000, 65535);
        endcase
    endfunction

    // Mostly requests that pass the checks, some rejected ones, and raw noise.
    function automatic isp_pkg::t_in_item random_request();
        isp_pkg::t_in_item req;
        int                sel;
        longint            w, h, n;
        sel = $urandom_range(99);
        if (sel < 70) begin
            n = $urandom_range(1, isp_pkg::MAX_SEGS);
            do begin
                w = random_dim();
                h = random_dim();
            end while (w * h < n * isp_pkg::MIN_SEGMENT_PIXELS);
        end else if (sel < 90) begin
            n = $urandom_range(1, isp_pkg::MAX_SEGS);
            w = random_dim();
            h = random_dim();
            case ($urandom_range(4))
                0: n = 0;
                1: n = $urandom_range(isp_pkg::MAX_SEGS + 1, 63);
                2: w = 0;
                3: h = 0;
                default: begin
                    w = $urandom_range(1, 64);
                    h = $urandom_range(0, int'((n * isp_pkg::MIN_SEGMENT_PIXELS - 1) / w));
                end
            endcase
        end else begin
            return isp_pkg::t_in_item'(38'({$urandom, $urandom}));
        end
        req.width_px      = 16'(w);
        req.height_px     = 16'(h);
        req.segment_count = 6'(n);
        return req;
    endfunction

    task automatic send_request(input isp_pkg::t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // Receiver: random stalls, plus one long hold-off on request so the block backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        int p;
        idle_by_phase  = '{0, 60, 0, 21};
        stall_by_phase = '{0, 0, 60, 21};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: extremes, exact and just-short areas, rejects, band shapes.
        send_request({16'd65535, 16'd65535, 6'd32});
        send_request({16'd16, 16'd16, 6'd1});
        send_request({16'd16, 16'd15, 6'd1});
        send_request({16'd256, 16'd1, 6'd1});
        send_request({16'd1, 16'd256, 6'd1});
        send_request({16'd64, 16'd128, 6'd32});
        send_request({16'd64, 16'd127, 6'd32});
        send_request({16'd1, 16'd65535, 6'd32});
        send_request({16'd65535, 16'd1, 6'd32});
        send_request({16'd1000, 16'd1000, 6'd0});
        send_request({16'd1000, 16'd1000, 6'd33});
        send_request({16'd65535, 16'd65535, 6'd63});
        send_request({16'd0, 16'd65535, 6'd1});
        send_request({16'd65535, 16'd0, 6'd1});
        send_request({16'd0, 16'd0, 6'd0});
        send_request({16'd1000, 16'd700, 6'd7});
        send_request({16'd640, 16'd480, 6'd5});
        send_request({16'd1920, 16'd1080, 6'd13});
        send_request({16'd4096, 16'd4096, 6'd31});
        send_request({16'd300, 16'd200, 6'd2});
        send_request({16'd200, 16'd300, 6'd3});
        send_request({16'h5555, 16'haaaa, 6'd21});
        send_request({16'haaaa, 16'h5555, 6'd10});
        send_request({16'd17, 16'd4000, 6'd11});

        for (p = 0; p < 4; p++) begin
            send_idle_pct = idle_by_phase[p];
            out_stall_pct = stall_by_phase[p];
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end

        // The sender keeps offering items while the receiver holds off for a long stretch.
        send_idle_pct    = 0;
        out_stall_pct    = 20;
        hold_off_pending = 1'b1;
        repeat (ITEMS_PER_PHASE) send_request(random_request());
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d segments never arrived", mismatches, outstanding);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
